// ===== rtl/wfa_pkg.sv =====
// Shared types, widths and codes of the worst-fit allocator.
package wfa_pkg;

  localparam int unsigned SIZE_W      = 31;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEF_MAX_REQ = 1024;
  localparam int unsigned DEF_MAX_FB  = 1025;

  localparam logic [SIZE_W-1:0] MEM_SIZE_RST = SIZE_W'(1024);

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DECLINED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOG_FULL  = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } ext_t;

  typedef struct packed {
    logic              live;
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } log_t;

endpackage

// ===== rtl/wfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/worst_fit_allocator_coalescing_core.sv =====
// Worst-fit allocator with coalescing: free table and request log in RAM.
// An allocate scans the free table, shrinks or drops the chosen extent, writes the log;
// a free reads the log, scans, merges or adds the extent, clears and writes the log.
// Free-table entries are read one per cycle. A full log goes straight to the result; a
// zero size or dead index only writes the log. One word at a time, the next taken once
// the result is loaded. A reset or size write rebuilds the table before taking words.
module worst_fit_allocator_coalescing_core
  import wfa_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS    = DEF_MAX_REQ,
  parameter int unsigned MAX_FREE_BLOCKS = DEF_MAX_FB
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_memory_size_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_operation_i,
  input  logic [SIZE_W-1:0]   in_alloc_size_i,
  input  logic [IDX_W-1:0]    in_request_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [SIZE_W-1:0]   out_block_start_o
);

  localparam int unsigned FAW = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned FCW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned LAW = $clog2(MAX_REQUESTS);
  localparam int unsigned LCW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned XW  = (LCW > IDX_W) ? LCW : IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG_RD, S_SCAN, S_ALLOC_FIN, S_FREE_FIN,
    S_DROP_RD, S_DROP_WR, S_LOG_CLR, S_LOG_WR, S_DONE
  } state_e;

  state_e state_q;
  logic   init_q;
  logic [SIZE_W-1:0]   mem_size_q;
  logic [LCW-1:0]      count_q;
  logic [FCW-1:0]      fc_q;
  logic [FCW-1:0]      i_q;
  logic                rv_q;
  logic [FAW-1:0]      ri_q;
  logic                op_q;
  logic [SIZE_W-1:0]   size_q;
  logic [LAW-1:0]      idx_q;
  logic                found_q;
  logic [SIZE_W-1:0]   best_start_q, best_len_q;
  logic [FAW-1:0]      best_idx_q;
  logic [SIZE_W-1:0]   fstart_q, flen_q, fend_q;
  logic                has_l_q, has_r_q;
  logic [FAW-1:0]      l_idx_q, r_idx_q, tgt_q;
  logic [SIZE_W-1:0]   l_start_q, l_len_q, r_len_q;
  log_t                lg_q;
  logic [STATUS_W-1:0] status_q;
  logic [SIZE_W-1:0]   bstart_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SIZE_W-1:0]   out_start_q;

  logic           ft_we;
  logic [FAW-1:0] ft_waddr, ft_raddr;
  ext_t           ft_wdata, ft_rdata;
  logic           lg_we;
  logic [LAW-1:0] lg_waddr, lg_raddr;
  log_t           lg_wdata, lg_rdata;

  logic [FCW-1:0] fc_m1;
  logic [XW-1:0]  idx_x, count_x;
  logic           accept;

  assign fc_m1   = fc_q - 1'b1;
  assign idx_x   = XW'(in_request_index_i);
  assign count_x = XW'(count_q);
  assign in_stall_o = !((state_q == S_IDLE) && !init_q);
  assign accept  = in_valid_i && !in_stall_o;

  wfa_ram #(.WIDTH($bits(ext_t)), .DEPTH(MAX_FREE_BLOCKS)) u_free_table (
    .clk_i   (clk_i),
    .we_i    (ft_we),
    .waddr_i (ft_waddr),
    .wdata_i (ft_wdata),
    .raddr_i (ft_raddr),
    .rdata_o (ft_rdata)
  );

  wfa_ram #(.WIDTH($bits(log_t)), .DEPTH(MAX_REQUESTS)) u_request_log (
    .clk_i   (clk_i),
    .we_i    (lg_we),
    .waddr_i (lg_waddr),
    .wdata_i (lg_wdata),
    .raddr_i (lg_raddr),
    .rdata_o (lg_rdata)
  );

  always_comb begin
    ft_we    = 1'b0;
    ft_waddr = '0;
    ft_wdata = '0;
    ft_raddr = i_q[FAW-1:0];
    lg_we    = 1'b0;
    lg_waddr = count_q[LAW-1:0];
    lg_wdata = lg_q;
    lg_raddr = idx_x[LAW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (init_q) begin
          ft_we    = 1'b1;
          ft_wdata = '{start: '0, len: mem_size_q};
        end
      end
      S_ALLOC_FIN: begin
        if (found_q && best_len_q > size_q) begin
          ft_we    = 1'b1;
          ft_waddr = best_idx_q;
          ft_wdata = '{start: best_start_q + size_q, len: best_len_q - size_q};
        end
      end
      S_FREE_FIN: begin
        if (has_l_q) begin
          ft_we    = 1'b1;
          ft_waddr = l_idx_q;
          ft_wdata = '{start: l_start_q,
                       len: l_len_q + flen_q + (has_r_q ? r_len_q : '0)};
        end else if (has_r_q) begin
          ft_we    = 1'b1;
          ft_waddr = r_idx_q;
          ft_wdata = '{start: fstart_q, len: r_len_q + flen_q};
        end else if (fc_q < FCW'(MAX_FREE_BLOCKS)) begin
          ft_we    = 1'b1;
          ft_waddr = fc_q[FAW-1:0];
          ft_wdata = '{start: fstart_q, len: flen_q};
        end
      end
      S_DROP_RD: ft_raddr = fc_m1[FAW-1:0];
      S_DROP_WR: begin
        ft_we    = 1'b1;
        ft_waddr = tgt_q;
        ft_wdata = ft_rdata;
      end
      S_LOG_CLR: begin
        lg_we    = 1'b1;
        lg_waddr = idx_q;
        lg_wdata = '0;
      end
      S_LOG_WR: lg_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_q      <= 1'b1;
      mem_size_q  <= MEM_SIZE_RST;
      count_q     <= '0;
      fc_q        <= FCW'(1);
      i_q         <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        mem_size_q <= cfg_memory_size_i;
        count_q    <= '0;
        fc_q       <= (cfg_memory_size_i != '0) ? FCW'(1) : '0;
        init_q     <= 1'b1;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (init_q) begin
              init_q <= 1'b0;
            end else if (accept) begin
              op_q   <= in_operation_i;
              size_q <= in_alloc_size_i;
              idx_q  <= idx_x[LAW-1:0];
              lg_q   <= '0;
              i_q    <= '0;
              rv_q   <= 1'b0;
              found_q <= 1'b0;
              bstart_q <= '0;
              if (count_q == LCW'(MAX_REQUESTS)) begin
                status_q <= ST_LOG_FULL;
                state_q  <= S_DONE;
              end else if (in_operation_i == OP_ALLOC) begin
                if (in_alloc_size_i == '0) begin
                  status_q <= ST_DECLINED;
                  state_q  <= S_LOG_WR;
                end else begin
                  state_q <= S_SCAN;
                end
              end else if (idx_x >= count_x) begin
                status_q <= ST_IGNORED;
                state_q  <= S_LOG_WR;
              end else begin
                state_q <= S_LOG_RD;
              end
            end
          end
          S_LOG_RD: begin
            if (!lg_rdata.live) begin
              status_q <= ST_IGNORED;
              state_q  <= S_LOG_WR;
            end else begin
              fstart_q <= lg_rdata.start;
              flen_q   <= lg_rdata.len;
              fend_q   <= lg_rdata.start + lg_rdata.len;
              has_l_q  <= 1'b0;
              has_r_q  <= 1'b0;
              state_q  <= S_SCAN;
            end
          end
          S_SCAN: begin
            rv_q <= i_q < fc_q;
            ri_q <= i_q[FAW-1:0];
            if (i_q < fc_q) begin
              i_q <= i_q + 1'b1;
            end
            if (rv_q) begin
              if (op_q == OP_ALLOC) begin
                if (!found_q || ft_rdata.len > best_len_q ||
                    (ft_rdata.len == best_len_q && ft_rdata.start < best_start_q)) begin
                  found_q      <= 1'b1;
                  best_idx_q   <= ri_q;
                  best_start_q <= ft_rdata.start;
                  best_len_q   <= ft_rdata.len;
                end
              end else if (!has_l_q && ft_rdata.start + ft_rdata.len == fstart_q) begin
                has_l_q   <= 1'b1;
                l_idx_q   <= ri_q;
                l_start_q <= ft_rdata.start;
                l_len_q   <= ft_rdata.len;
              end else if (!has_r_q && ft_rdata.start == fend_q) begin
                has_r_q <= 1'b1;
                r_idx_q <= ri_q;
                r_len_q <= ft_rdata.len;
              end
            end
            if (!rv_q && i_q >= fc_q) begin
              state_q <= (op_q == OP_ALLOC) ? S_ALLOC_FIN : S_FREE_FIN;
            end
          end
          S_ALLOC_FIN: begin
            if (!found_q || best_len_q < size_q) begin
              status_q <= ST_DECLINED;
              state_q  <= S_LOG_WR;
            end else begin
              status_q <= ST_ALLOCATED;
              bstart_q <= best_start_q;
              lg_q     <= '{live: 1'b1, start: best_start_q, len: size_q};
              tgt_q    <= best_idx_q;
              state_q  <= (best_len_q == size_q) ? S_DROP_RD : S_LOG_WR;
            end
          end
          S_FREE_FIN: begin
            status_q <= ST_FREED;
            if (has_l_q && has_r_q) begin
              tgt_q   <= r_idx_q;
              state_q <= S_DROP_RD;
            end else if (has_l_q || has_r_q) begin
              state_q <= S_LOG_CLR;
            end else if (fc_q < FCW'(MAX_FREE_BLOCKS)) begin
              fc_q    <= fc_q + 1'b1;
              state_q <= S_LOG_CLR;
            end else begin
              status_q <= ST_IGNORED;
              state_q  <= S_LOG_WR;
            end
          end
          S_DROP_RD: state_q <= S_DROP_WR;
          S_DROP_WR: begin
            fc_q    <= fc_m1;
            state_q <= (op_q == OP_ALLOC) ? S_LOG_WR : S_LOG_CLR;
          end
          S_LOG_CLR: state_q <= S_LOG_WR;
          S_LOG_WR: begin
            count_q <= count_q + 1'b1;
            state_q <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid_q || !out_stall_i) begin
              out_valid_q  <= 1'b1;
              out_status_q <= status_q;
              out_start_q  <= bstart_q;
              state_q      <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_block_start_o = out_start_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the worst-fit allocator with coalescing.
`timescale 1ns / 100ps

module testbench;
  import wfa_pkg::*;

  localparam int unsigned NREQ     = DEF_MAX_REQ;
  localparam int unsigned LIMIT    = 20000;
  localparam int unsigned SETTLE   = 2200;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   start;
  } word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [SIZE_W-1:0]   cfg_memory_size_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                in_operation_i = OP_ALLOC;
  logic [SIZE_W-1:0]   in_alloc_size_i = '0;
  logic [IDX_W-1:0]    in_request_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] out_status_o;
  logic [SIZE_W-1:0]   out_block_start_o;

  worst_fit_allocator_coalescing_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_memory_size_i(cfg_memory_size_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_operation_i(in_operation_i), .in_alloc_size_i(in_alloc_size_i),
    .in_request_index_i(in_request_index_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_status_o(out_status_o), .out_block_start_o(out_block_start_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // allocator shadow state
  logic [SIZE_W-1:0] mem_size;
  logic [SIZE_W-1:0] ft_start[$];
  logic [SIZE_W-1:0] ft_len[$];
  logic              log_live[NREQ];
  logic [SIZE_W-1:0] log_start[NREQ];
  logic [SIZE_W-1:0] log_len[NREQ];
  int unsigned       req_count;

  word_t       pending[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned n_alloc = 0, n_freed = 0;

  function automatic void clear_heap();
    ft_start.delete();
    ft_len.delete();
    for (int i = 0; i < NREQ; i++) begin
      log_live[i] = 1'b0;
    end
    req_count = 0;
    if (mem_size != 0) begin
      ft_start.insert(ft_start.size(), SIZE_W'(0));
      ft_len.insert(ft_len.size(), mem_size);
    end
  endfunction

  function automatic void drop_ext(int i);
    int last;
    last = ft_start.size() - 1;
    ft_start[i] = ft_start[last];
    ft_len[i] = ft_len[last];
    ft_start.delete(last);
    ft_len.delete(last);
  endfunction

  function automatic word_t allocate_next(logic op, logic [SIZE_W-1:0] sz,
                                          logic [IDX_W-1:0] idx);
    word_t r;
    int best, lt, rt;
    logic [SIZE_W-1:0] s, l, e;
    r.status = ST_IGNORED;
    r.start = '0;
    if (req_count >= NREQ) begin
      r.status = ST_LOG_FULL;
      return r;
    end
    log_live[req_count] = 1'b0;
    if (op == OP_ALLOC) begin
      r.status = ST_DECLINED;
      best = -1;
      for (int i = 0; i < ft_start.size(); i++) begin
        if (best < 0 || ft_len[i] > ft_len[best] ||
            (ft_len[i] == ft_len[best] && ft_start[i] < ft_start[best])) begin
          best = i;
        end
      end
      if (sz != 0 && best >= 0 && ft_len[best] >= sz) begin
        r.status = ST_ALLOCATED;
        r.start = ft_start[best];
        log_live[req_count] = 1'b1;
        log_start[req_count] = ft_start[best];
        log_len[req_count] = sz;
        if (ft_len[best] == sz) begin
          drop_ext(best);
        end else begin
          ft_start[best] += sz;
          ft_len[best] -= sz;
        end
      end
    end else if (idx < req_count && log_live[idx]) begin
      s = log_start[idx];
      l = log_len[idx];
      e = s + l;
      lt = -1;
      rt = -1;
      for (int i = 0; i < ft_start.size(); i++) begin
        if (lt < 0 && ft_start[i] + ft_len[i] == s) begin
          lt = i;
        end else if (rt < 0 && ft_start[i] == e) begin
          rt = i;
        end
      end
      if (lt < 0 && rt < 0) begin
        if (ft_start.size() < DEF_MAX_FB) begin
          ft_start.insert(ft_start.size(), s);
          ft_len.insert(ft_len.size(), l);
          r.status = ST_FREED;
        end
      end else begin
        r.status = ST_FREED;
        if (lt >= 0 && rt >= 0) begin
          ft_len[lt] += l + ft_len[rt];
          drop_ext(rt);
        end else if (lt >= 0) begin
          ft_len[lt] += l;
        end else begin
          ft_start[rt] = s;
          ft_len[rt] += l;
        end
      end
      if (r.status == ST_FREED) begin
        log_live[idx] = 1'b0;
      end
    end
    req_count++;
    return r;
  endfunction

  // receiver: own stall pattern, checks each word
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: status %0d start %0d", out_status_o,
                     out_block_start_o);
          end
        end else begin
          w = pending.pop_front();
          if (w.status !== out_status_o || w.start !== out_block_start_o) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d start %0d, got %0d %0d",
                       w.status, w.start, out_status_o, out_block_start_o);
            end
          end
        end
      end
      case (words_seen % 64 < 16 ? 0 : $urandom_range(2))
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3) == 0);
        default: out_stall_i <= ($urandom_range(1) == 0);
      endcase
      if (idle_cycles > LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [SIZE_W-1:0] sz, logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      repeat ($urandom_range(3)) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_operation_i <= op;
    in_alloc_size_i <= sz;
    in_request_index_i <= idx;
    pending.insert(pending.size(), allocate_next(op, sz, idx));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    words_sent++;
    // the core stalls its input after taking a word
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] sz);
    drain();
    cfg_we_i <= 1'b1;
    cfg_memory_size_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_size = sz;
    clear_heap();
    @(posedge clk_i);
  endtask

  task automatic rand_alloc(int unsigned hi);
    send_word(OP_ALLOC, SIZE_W'($urandom_range(hi, 1)), IDX_W'($urandom));
  endtask

  task automatic rand_free();
    send_word(OP_FREE, SIZE_W'($urandom),
              IDX_W'(req_count == 0 ? 0 : $urandom_range(req_count - 1)));
  endtask

  task automatic test_directed();
    send_word(OP_ALLOC, '0, '1);
    send_word(OP_ALLOC, 31'd100, '0);
    send_word(OP_ALLOC, 31'd200, '0);
    send_word(OP_ALLOC, 31'd300, '0);
    send_word(OP_FREE, '1, 10'd2);
    send_word(OP_FREE, '0, 10'd2);
    send_word(OP_FREE, '0, 10'd0);
    send_word(OP_FREE, '0, 10'd4);
    send_word(OP_FREE, '0, 10'd1023);
    send_word(OP_FREE, '0, 10'd1);
    send_word(OP_FREE, '0, 10'd3);
    send_word(OP_ALLOC, 31'd1024, '0);
    send_word(OP_ALLOC, 31'd1, '0);
    send_word(OP_ALLOC, '1, '0);
    set_size('1);
    send_word(OP_ALLOC, 31'h3fff_ffff, '0);
    send_word(OP_ALLOC, 31'h4000_0000, '0);
    send_word(OP_ALLOC, 31'h4000_0000, '0);
    send_word(OP_FREE, '0, 10'd0);
    set_size('0);
    send_word(OP_ALLOC, 31'd1, '0);
    send_word(OP_FREE, '0, 10'd0);
    set_size(31'd1);
    send_word(OP_ALLOC, 31'd1, '0);
    send_word(OP_FREE, '0, 10'd0);
  endtask

  task automatic test_random(int unsigned n, int unsigned hi);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 5) rand_alloc(hi);
      else if ($urandom_range(9) == 0) send_word(OP_ALLOC, SIZE_W'($urandom), IDX_W'($urandom));
      else rand_free();
    end
  endtask

  initial begin
    mem_size = MEM_SIZE_RST;
    clear_heap();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_size(31'd64);
    test_random(250, 12);
    set_size(31'd4096);
    test_random(180, 600);
    set_size(31'h7fff_fff0);
    test_random(120, 31'h7fff_ffff);
    drain();
    $display("Covered %0d words (%0d allocs served, %0d freed) over several memory sizes,",
             words_sent, n_alloc, n_freed);
    $display("including zero, one and maximum sizes with random sender gaps and stalls.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (out_status_o == ST_ALLOCATED) n_alloc++;
      if (out_status_o == ST_FREED) n_freed++;
    end
  end

endmodule

// ===== sim.f =====
rtl/wfa_pkg.sv
rtl/wfa_ram.sv
rtl/worst_fit_allocator_coalescing_core.sv
tb/sv/testbench.sv
